@@ rtl/core/sskt_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the sparse-set keyed table
package sskt_pkg;

   localparam int KEYS      = 1024;
   localparam int KEY_W     = 10;
   localparam int CMD_W     = 3;
   localparam int DATA_W    = 32;
   localparam int MEMBERS_W = 11;
   localparam int IDX_W     = (KEYS > 1) ? $clog2(KEYS) : 1;
   localparam int TOP_W     = IDX_W + 1;
   localparam int SLOT_W    = KEY_W + 1;

   localparam logic signed [DATA_W-1:0] DATA_ABSENT = -1;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT    = 3'd0,
      CMD_REMOVE    = 3'd1,
      CMD_CLEAR_ALL = 3'd2,
      CMD_COUNT     = 3'd3,
      CMD_QUERY     = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_READ_SLOT,
      ST_DECIDE
   } state_type;

   typedef struct packed {
      logic capture;
      logic read_slot;
      logic commit;
      logic sweep_step;
   } ctrl_cmd_type;

   typedef struct packed {
      logic sweep_last;
   } ctrl_status_type;

endpackage

@@ rtl/core/sskt_ram.sv @@
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
module sskt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/sskt_ctrl.sv @@
`timescale 1ns / 1ps
// controller state machine: sweep after reset, lookup sequencing, result hand-off
module sskt_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  sskt_pkg::ctrl_status_type status,
   output sskt_pkg::ctrl_cmd_type    cmd
);

   import sskt_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_SWEEP: begin
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_READ_SLOT;
            end
         end
         ST_READ_SLOT: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_SWEEP;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_SWEEP: begin
            cmd.sweep_step = 1'b1;
         end
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_READ_SLOT: begin
            cmd.read_slot = 1'b1;
         end
         ST_DECIDE: begin
            cmd.commit = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/core/sskt_dp.sv @@
`timescale 1ns / 1ps
// datapath: order table, check stack, value store, top pointer, count, result register
module sskt_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  sskt_pkg::ctrl_cmd_type              cmd,
   output sskt_pkg::ctrl_status_type           status,
   input  logic [sskt_pkg::CMD_W-1:0]          req_cmd,
   input  logic [sskt_pkg::KEY_W-1:0]          req_key,
   input  logic signed [sskt_pkg::DATA_W-1:0]  req_value,
   output logic                                rsp_present,
   output logic signed [sskt_pkg::DATA_W-1:0]  rsp_data,
   output logic [sskt_pkg::MEMBERS_W-1:0]      rsp_members
);

   import sskt_pkg::*;

   logic [CMD_W-1:0]         cmd_ff;
   logic [KEY_W-1:0]         key_ff;
   logic signed [DATA_W-1:0] value_ff;
   logic [TOP_W-1:0]         top_ff, top_in;
   logic [MEMBERS_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]         sweep_addr_ff;
   logic                     rsp_present_ff;
   logic signed [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [MEMBERS_W-1:0]     rsp_members_ff;

   logic [IDX_W-1:0]  ord_rd, ord_wr_addr, ord_wr_data;
   logic              ord_we;
   logic [SLOT_W-1:0] cs_rd, cs_wr_data, key_entry;
   logic [IDX_W-1:0]  cs_wr_addr, slot;
   logic              cs_we;
   logic [DATA_W-1:0] val_rd;
   logic              val_we;

   logic key_ok, slot_ok, here, erased, top_full;
   logic is_insert, is_remove, is_clear, is_query;
   logic do_insert, new_member, alloc, do_remove;

   assign key_entry = {1'b0, key_ff};
   assign key_ok    = 32'(key_ff) < 32'(KEYS);
   assign slot_ok   = {1'b0, ord_rd} < top_ff;
   assign here      = key_ok && slot_ok && (cs_rd == key_entry);
   assign erased    = slot_ok && (cs_rd == ~key_entry);
   assign top_full  = top_ff == TOP_W'(KEYS);

   assign is_insert = cmd_ff == CMD_INSERT;
   assign is_remove = cmd_ff == CMD_REMOVE;
   assign is_clear  = cmd_ff == CMD_CLEAR_ALL;
   assign is_query  = cmd_ff == CMD_QUERY;

   assign do_insert  = cmd.commit && is_insert && key_ok;
   assign new_member = do_insert && !here;
   assign alloc      = new_member && !erased && !top_full;
   assign do_remove  = cmd.commit && is_remove && here;
   assign slot       = alloc ? top_ff[IDX_W-1:0] : ord_rd;

   assign status.sweep_last = sweep_addr_ff == IDX_W'(KEYS - 1);

   always_comb begin
      if (cmd.sweep_step) begin
         ord_we      = 1'b1;
         ord_wr_addr = sweep_addr_ff;
         ord_wr_data = '0;
      end else begin
         ord_we      = alloc;
         ord_wr_addr = IDX_W'(key_ff);
         ord_wr_data = top_ff[IDX_W-1:0];
      end
   end

   always_comb begin
      cs_we      = new_member || do_remove;
      cs_wr_addr = slot;
      cs_wr_data = new_member ? key_entry : ~key_entry;
   end

   assign val_we = do_insert;

   always_comb begin
      top_in   = top_ff;
      count_in = count_ff;
      if (cmd.commit && is_clear) begin
         top_in   = '0;
         count_in = '0;
      end else begin
         if (alloc) begin
            top_in = top_ff + TOP_W'(1);
         end
         if (new_member) begin
            count_in = count_ff + MEMBERS_W'(1);
         end else if (do_remove) begin
            count_in = count_ff - MEMBERS_W'(1);
         end
      end
   end

   always_comb begin
      if (!is_query) begin
         rsp_data_in = '0;
      end else if (here) begin
         rsp_data_in = val_rd;
      end else begin
         rsp_data_in = DATA_ABSENT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff        <= '0;
         count_ff      <= '0;
         sweep_addr_ff <= '0;
      end else begin
         top_ff   <= top_in;
         count_ff <= count_in;
         if (cmd.sweep_step) begin
            sweep_addr_ff <= sweep_addr_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff   <= req_cmd;
         key_ff   <= req_key;
         value_ff <= req_value;
      end
      if (cmd.commit) begin
         rsp_present_ff <= here;
         rsp_data_ff    <= rsp_data_in;
         rsp_members_ff <= count_in;
      end
   end

   sskt_ram #(.WIDTH(IDX_W), .DEPTH(KEYS)) u_order (
      .clock   (clock),
      .wr_en   (ord_we),
      .wr_addr (ord_wr_addr),
      .wr_data (ord_wr_data),
      .rd_en   (cmd.capture),
      .rd_addr (IDX_W'(req_key)),
      .rd_data (ord_rd)
   );

   sskt_ram #(.WIDTH(SLOT_W), .DEPTH(KEYS)) u_check (
      .clock   (clock),
      .wr_en   (cs_we),
      .wr_addr (cs_wr_addr),
      .wr_data (cs_wr_data),
      .rd_en   (cmd.read_slot),
      .rd_addr (ord_rd),
      .rd_data (cs_rd)
   );

   sskt_ram #(.WIDTH(DATA_W), .DEPTH(KEYS)) u_value (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (IDX_W'(key_ff)),
      .wr_data (value_ff),
      .rd_en   (cmd.capture),
      .rd_addr (IDX_W'(req_key)),
      .rd_data (val_rd)
   );

   assign rsp_present = rsp_present_ff;
   assign rsp_data    = rsp_data_ff;
   assign rsp_members = rsp_members_ff;

`ifndef SYNTH
   a_top_bound: assert property (@(posedge clock) disable iff (reset)
      top_ff <= TOP_W'(KEYS))
      else $error("stack top beyond table size");

   a_clear_all: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && is_clear |=> top_ff == '0 && count_ff == '0)
      else $error("clear all did not reset top and count");

   a_alloc_step: assert property (@(posedge clock) disable iff (reset)
      alloc |=> top_ff == $past(top_ff) + TOP_W'(1))
      else $error("slot allocation did not advance the top");

   a_no_write_in_sweep: assert property (@(posedge clock) disable iff (reset)
      cmd.sweep_step |-> !cs_we && !val_we && !cmd.capture)
      else $error("table write or capture during sweep");
`endif

endmodule

@@ rtl/core/sparse_set_keyed_table_unit.sv @@
`timescale 1ns / 1ps
// top level of the sparse-set keyed table with constant-time clear
//
//   channel   direction   handshake                 payload
//   req_      in          req_valid / req_stall     req_cmd, req_key, req_value
//   rsp_      out         rsp_valid / rsp_stall     rsp_present, rsp_data, rsp_members
//
// one transaction at a time: accept, order table read, check stack read and commit
// the check stack read depends on the order table read, each a registered ram port
// after reset every order table entry is swept to zero, req_stall high
// a waiting result is held in the output register while the next request is taken
// a stalled result delays only the commit step of the following transaction
module sparse_set_keyed_table_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [sskt_pkg::CMD_W-1:0]          req_cmd,
   input  logic [sskt_pkg::KEY_W-1:0]          req_key,
   input  logic signed [sskt_pkg::DATA_W-1:0]  req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_present,
   output logic signed [sskt_pkg::DATA_W-1:0]  rsp_data,
   output logic [sskt_pkg::MEMBERS_W-1:0]      rsp_members
);

   import sskt_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   sskt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sskt_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_cmd     (req_cmd),
      .req_key     (req_key),
      .req_value   (req_value),
      .rsp_present (rsp_present),
      .rsp_data    (rsp_data),
      .rsp_members (rsp_members)
   );

endmodule

@@ bench/sparse_set_keyed_table_checker.sv @@
`timescale 1ns / 1ps
// checker for the sparse-set keyed table: watches both channels, predicts and compares
module sparse_set_keyed_table_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [sskt_pkg::CMD_W-1:0]          req_cmd,
   input  logic [sskt_pkg::KEY_W-1:0]          req_key,
   input  logic signed [sskt_pkg::DATA_W-1:0]  req_value,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic                                rsp_present,
   input  logic signed [sskt_pkg::DATA_W-1:0]  rsp_data,
   input  logic [sskt_pkg::MEMBERS_W-1:0]      rsp_members,
   output int unsigned                         fail_count,
   output int unsigned                         pending
);

   import sskt_pkg::*;

   typedef struct {
      logic                     present;
      logic signed [DATA_W-1:0] data;
      logic [MEMBERS_W-1:0]     members;
   } table_reply_type;

   int unsigned              order_tbl [KEYS];
   int                       chk_stack [KEYS];
   logic signed [DATA_W-1:0] val_store [KEYS];
   int unsigned              top_ptr;
   int unsigned              member_cnt;
   table_reply_type          reply_q [$];
   table_reply_type          want;

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got_v,
                                  input logic [DATA_W-1:0] want_v);
      fail_count++;
      $display("ERROR: %s: got 0x%0h, want 0x%0h at %0t", what, got_v, want_v, $time);
   endtask

   function automatic table_reply_type table_apply(input logic [CMD_W-1:0] c,
                                                   input logic [KEY_W-1:0] k,
                                                   input logic signed [DATA_W-1:0] v);
      table_reply_type rep;
      int unsigned     slot;
      bit              here;
      bit              erased;
      slot   = order_tbl[k];
      here   = slot < top_ptr && slot < KEYS && chk_stack[slot] == int'(k);
      erased = slot < top_ptr && slot < KEYS && chk_stack[slot] == -1 - int'(k);
      rep.present = here;
      rep.data    = '0;
      case (c)
         CMD_INSERT: begin
            if (!here) begin
               if (!erased && top_ptr < KEYS) begin
                  order_tbl[k] = top_ptr;
                  top_ptr++;
               end
               if (order_tbl[k] < KEYS)
                  chk_stack[order_tbl[k]] = int'(k);
               member_cnt++;
            end
            val_store[k] = v;
         end
         CMD_REMOVE: begin
            if (here) begin
               chk_stack[order_tbl[k]] = -1 - int'(k);
               val_store[k] = DATA_ABSENT;
               member_cnt--;
            end
         end
         CMD_CLEAR_ALL: begin
            top_ptr    = 0;
            member_cnt = 0;
         end
         CMD_QUERY: begin
            rep.data = here ? val_store[k] : DATA_ABSENT;
         end
         default: ;
      endcase
      rep.members = MEMBERS_W'(member_cnt);
      return rep;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEYS; i++) begin
            order_tbl[i] = 0;
            chk_stack[i] = 0;
            val_store[i] = '0;
         end
         top_ptr    = 0;
         member_cnt = 0;
         fail_count = 0;
         reply_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (reply_q.size() == 0) begin
               report_mismatch("result with no transaction outstanding", rsp_data, '0);
            end else begin
               want = reply_q.pop_front();
               if (rsp_present !== want.present)
                  report_mismatch("present", DATA_W'(rsp_present), DATA_W'(want.present));
               if (rsp_data !== want.data)
                  report_mismatch("data", rsp_data, want.data);
               if (rsp_members !== want.members)
                  report_mismatch("members", DATA_W'(rsp_members), DATA_W'(want.members));
            end
         end
         if (req_valid && !req_stall)
            reply_q.push_back(table_apply(req_cmd, req_key, req_value));
      end
      pending = reply_q.size();
   end

endmodule

@@ bench/tb_sparse_set_keyed_table_unit.sv @@
`timescale 1ns / 1ps
// testbench top for the sparse-set keyed table: stimulus, response stalls and verdict
module tb_sparse_set_keyed_table_unit;
   import sskt_pkg::*;

   localparam logic [CMD_W-1:0] CMD_LAST_CODE = '1;
   localparam int               POOL_SIZE     = 24;
   localparam int               HOLD_CYCLES   = 200;
   localparam int               CYCLE_LIMIT   = 120000;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [CMD_W-1:0]         req_cmd;
   logic [KEY_W-1:0]         req_key;
   logic signed [DATA_W-1:0] req_value;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic                     rsp_present;
   logic signed [DATA_W-1:0] rsp_data;
   logic [MEMBERS_W-1:0]     rsp_members;

   int unsigned      fail_count;
   int unsigned      pending;
   int unsigned      cycle_count;
   bit               quiet;
   bit               hold_go;
   logic [KEY_W-1:0] key_pool [POOL_SIZE];
   int               fill_order [KEYS];

   sparse_set_keyed_table_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_cmd     (req_cmd),
      .req_key     (req_key),
      .req_value   (req_value),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_present (rsp_present),
      .rsp_data    (rsp_data),
      .rsp_members (rsp_members)
   );

   sparse_set_keyed_table_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_cmd     (req_cmd),
      .req_key     (req_key),
      .req_value   (req_value),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_present (rsp_present),
      .rsp_data    (rsp_data),
      .rsp_members (rsp_members),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic bit take_break();
      return !quiet && $urandom_range(99) < 6;
   endfunction

   // result side: random stalls plus one long hold-off
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_stall <= take_break();
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_txn(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k,
                           input logic [DATA_W-1:0] v);
      while (take_break()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= c;
      req_key   <= k;
      req_value <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(9))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return '1;
         3:       return '0;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [KEY_W-1:0] pick_key();
      if ($urandom_range(99) < 70)
         return key_pool[$urandom_range(POOL_SIZE - 1)];
      return KEY_W'($urandom_range(KEYS - 1));
   endfunction

   task automatic send_mixed();
      int r;
      r = $urandom_range(99);
      if (r < 36)
         send_txn(CMD_INSERT, pick_key(), pick_value());
      else if (r < 52)
         send_txn(CMD_REMOVE, pick_key(), $urandom);
      else if (r < 82)
         send_txn(CMD_QUERY, pick_key(), $urandom);
      else if (r < 88)
         send_txn(CMD_COUNT, pick_key(), $urandom);
      else if (r < 90)
         send_txn(CMD_CLEAR_ALL, pick_key(), $urandom);
      else
         send_txn(CMD_W'($urandom_range(int'(CMD_LAST_CODE), int'(CMD_QUERY) + 1)),
                  pick_key(), $urandom);
   endtask

   initial begin
      int j;
      int t;
      cycle_count = 0;
      quiet       = 1'b0;
      hold_go     = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_cmd     = CMD_COUNT;
      req_key     = '0;
      req_value   = '0;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++)
         key_pool[i] = KEY_W'($urandom_range(KEYS - 1));
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed
      send_txn(CMD_COUNT, '0, '0);
      send_txn(CMD_QUERY, '0, '1);
      send_txn(CMD_REMOVE, '0, '0);
      send_txn(CMD_INSERT, '0, 32'h8000_0000);
      send_txn(CMD_INSERT, '1, 32'h7fff_ffff);
      send_txn(CMD_QUERY, '0, '0);
      send_txn(CMD_QUERY, '1, '0);
      send_txn(CMD_INSERT, '0, '1);
      send_txn(CMD_COUNT, '1, '0);
      send_txn(CMD_REMOVE, '1, '1);
      send_txn(CMD_REMOVE, '1, '0);
      send_txn(CMD_QUERY, '1, '0);
      send_txn(CMD_INSERT, '1, '0);
      send_txn(CMD_QUERY, '1, '1);
      for (int c = int'(CMD_QUERY) + 1; c <= int'(CMD_LAST_CODE); c++)
         send_txn(CMD_W'(c), (c % 2) ? '1 : '0, '1);
      send_txn(CMD_CLEAR_ALL, '1, '1);
      send_txn(CMD_QUERY, '0, '0);
      send_txn(CMD_COUNT, '0, '0);
      send_txn(CMD_INSERT, '0, 32'h5a5a_a5a5);
      send_txn(CMD_QUERY, '0, '0);
      send_txn(CMD_REMOVE, '0, '0);
      send_txn(CMD_INSERT, 10'h2aa, 32'h5555_5555);
      send_txn(CMD_QUERY, 10'h2aa, 32'haaaa_aaaa);

      // random mix, mostly over a small key pool, with the long result hold-off
      for (int n = 0; n < 480; n++) begin
         if (n == 150)
            hold_go = 1'b1;
         send_mixed();
      end

      // fill every key in random order, no idling
      quiet = 1'b1;
      for (int i = 0; i < KEYS; i++)
         fill_order[i] = i;
      for (int i = KEYS - 1; i > 0; i--) begin
         j = $urandom_range(i);
         t = fill_order[i];
         fill_order[i] = fill_order[j];
         fill_order[j] = t;
      end
      send_txn(CMD_CLEAR_ALL, '0, '0);
      for (int i = 0; i < KEYS; i++)
         send_txn(CMD_INSERT, KEY_W'(fill_order[i]), pick_value());
      quiet = 1'b0;

      for (int n = 0; n < 45; n++)
         send_mixed();

      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (16) @(negedge clock);
      if (fail_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
